// ===== rtl/tpm_pkg.sv =====
package tpm_pkg;

  // Field and register widths
  localparam int PERIOD_W = 17;
  localparam int SCALE_W  = 3;
  localparam int SPEED_W  = 10;

  // Ring of group means and grouping of accepted periods
  localparam int RING_DEPTH = 5;
  localparam int GROUP_SIZE = 3;

  localparam int POS_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int COUNT_W = $clog2(GROUP_SIZE + 1);
  localparam int SUM_W   = PERIOD_W + COUNT_W;

  // floor(x / GROUP_SIZE) as (x * RECIP) >> SUM_W, exact for x below 2**SUM_W
  localparam int RECIP_W   = SUM_W + 1;
  localparam int RECIP_INT = ((1 << SUM_W) + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;

  // Median is the k-th largest entry: found by k passes of max extraction
  localparam int MED_RANK   = (RING_DEPTH + 1) / 2 - 1;
  localparam int MED_PASSES = RING_DEPTH - MED_RANK;
  localparam int STEP_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PASS_W     = (MED_PASSES > 1) ? $clog2(MED_PASSES) : 1;

  localparam int DIV_CNT_W = $clog2(PERIOD_W);
  localparam int SCALED_W  = PERIOD_W + SCALE_W;

  // Stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int OUT_BITS  = 1 + PERIOD_W + SPEED_W + 1;
  localparam int M_TDATA_W = 32;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 10'd1023;

  // Register reset values
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST    = 17'd390;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST    = 17'd78125;
  localparam logic [PERIOD_W-1:0] RPM_NUMERATOR_RST = 17'd78125;
  localparam logic [SCALE_W-1:0]  RPM_SCALE_RST     = 3'd2;

  typedef enum logic [1:0] {
    REG_MIN_PERIOD    = 2'd0,
    REG_MAX_PERIOD    = 2'd1,
    REG_RPM_NUMERATOR = 2'd2,
    REG_RPM_SCALE     = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_AVG,
    ST_WRITE,
    ST_SELECT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/tacho_period_median_rpm.sv =====
// Period tachometer: each item is one sensor period in timer ticks. Periods inside
// [min_period, max_period] are summed in groups of three; each group mean goes into a
// ring of five, and the block reports the ring median and the speed
// floor(rpm_numerator / median) * rpm_scale, saturated at 1023 (speed_valid low and
// speed zero while the median is zero). A new item is taken only when idle, after the
// current one has passed check, the 17-step restoring divider, scaling and output;
// while the median is zero the divider is skipped. On every third accepted period the
// ring is rewritten first and the median searched (mean, ring write and one comparator
// doing three 5-step max passes). A finished result sits in the output register, so the
// next item may be taken while it waits; that item stalls only if the earlier result
// is still waiting when it is done. Registers are written through cfg_wen / cfg_index /
// cfg_data; the user must do so only while the block is idle, which it does not enforce.
module tacho_period_median_rpm (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [tpm_pkg::S_TDATA_W-1:0]          s_tdata,   // [16:0] period_ticks
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [0] accepted, [17:1] median_period, [27:18] speed, [28] speed_valid
  output logic [tpm_pkg::M_TDATA_W-1:0]          m_tdata,
  input  logic                                   cfg_wen,
  input  tpm_pkg::cfg_index_t                    cfg_index,
  input  logic [tpm_pkg::PERIOD_W-1:0]           cfg_data
);
  import tpm_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

  state_t state, state_next;
  logic   load_out;

  // Configuration
  logic [PERIOD_W-1:0] min_period, max_period, rpm_numerator;
  logic [SCALE_W-1:0]  rpm_scale;

  // Tacho state
  logic [PERIOD_W-1:0] ring [RING_DEPTH];
  logic [SUM_W-1:0]    group_sum;
  logic [COUNT_W-1:0]  group_count;
  logic [POS_W-1:0]    ring_position;
  logic [PERIOD_W-1:0] median;

  // Working registers
  logic [PERIOD_W-1:0]   period;
  logic                  acc;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [PERIOD_W-1:0]   q [RING_DEPTH];
  logic [PERIOD_W-1:0]   carry;
  logic [STEP_W-1:0]     step;
  logic [PASS_W-1:0]     pass;
  logic [PERIOD_W-1:0]   rem, quo;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [SPEED_W-1:0]    speed;

  // Combinational datapath
  logic                  in_window, group_full;
  logic [SUM_W-1:0]      sum_next;
  logic [PERIOD_W-1:0]   avg;
  logic                  head_gt;
  logic [PERIOD_W-1:0]   pass_max, tail;
  logic                  step_last, pass_last;
  logic [PERIOD_W:0]     trial, diff;
  logic [SCALED_W-1:0]   scaled;

  assign in_window  = (period >= min_period) && (period <= max_period);
  assign group_full = (group_count == COUNT_W'(GROUP_SIZE - 1));
  assign sum_next   = group_sum + SUM_W'(period);
  assign avg        = avg_prod[SUM_W +: PERIOD_W];

  // Shared comparator of the median search: head of the rotating copy against the
  // running max; the loser goes back in at the tail
  assign head_gt   = q[0] > carry;
  assign pass_max  = head_gt ? q[0] : carry;
  assign tail      = head_gt ? carry : q[0];
  assign step_last = (step == STEP_W'(RING_DEPTH - 1));
  assign pass_last = (pass == PASS_W'(MED_PASSES - 1));

  assign trial  = {rem, quo[PERIOD_W-1]};
  assign diff   = trial - {1'b0, median};
  assign scaled = SCALED_W'(quo) * SCALED_W'(rpm_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (in_window && group_full) ? ST_AVG : ST_DIV_LOAD;
      end
      ST_AVG:   state_next = ST_WRITE;
      ST_WRITE: state_next = ST_SELECT;
      ST_SELECT: begin
        if (step_last && pass_last) state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        state_next = (median == '0) ? ST_SCALE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(PERIOD_W - 1)) state_next = ST_SCALE;
      end
      ST_SCALE: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Registers and tacho state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period    <= MIN_PERIOD_RST;
      max_period    <= MAX_PERIOD_RST;
      rpm_numerator <= RPM_NUMERATOR_RST;
      rpm_scale     <= RPM_SCALE_RST;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] <= '0;
      group_sum     <= '0;
      group_count   <= '0;
      ring_position <= '0;
      median        <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_MIN_PERIOD:    min_period    <= cfg_data;
          REG_MAX_PERIOD:    max_period    <= cfg_data;
          REG_RPM_NUMERATOR: rpm_numerator <= cfg_data;
          REG_RPM_SCALE:     rpm_scale     <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (state == ST_CHECK && in_window) begin
        group_sum   <= sum_next;
        group_count <= group_full ? '0 : group_count + COUNT_W'(1);
      end

      if (state == ST_WRITE) begin
        ring[ring_position] <= avg;
        group_sum           <= '0;
        ring_position <= (ring_position == POS_W'(RING_DEPTH - 1)) ? '0
                                                                   : ring_position + POS_W'(1);
      end

      if (state == ST_SELECT && step_last && pass_last) median <= pass_max;

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) period <= s_tdata[PERIOD_W-1:0];
      end
      ST_CHECK: begin
        acc      <= in_window;
        avg_prod <= '0;
      end
      ST_AVG: begin
        avg_prod <= AVG_PROD_W'(group_sum) * AVG_PROD_W'(RECIP);
      end
      ST_WRITE: begin
        // copy of the ring with the new mean already in place
        for (int i = 0; i < RING_DEPTH; i++) begin
          q[i] <= (POS_W'(i) == ring_position) ? avg : ring[i];
        end
        carry <= '0;
        step  <= '0;
        pass  <= '0;
      end
      ST_SELECT: begin
        for (int i = 0; i < RING_DEPTH - 1; i++) q[i] <= q[i + 1];
        q[RING_DEPTH-1] <= tail;
        if (step_last) begin
          // pass max drops out; the zero seed stays in its place
          carry <= '0;
          step  <= '0;
          pass  <= pass + PASS_W'(1);
        end else begin
          carry <= pass_max;
          step  <= step + STEP_W'(1);
        end
      end
      ST_DIV_LOAD: begin
        rem     <= '0;
        quo     <= (median == '0) ? '0 : rpm_numerator;
        div_cnt <= '0;
      end
      ST_DIV: begin
        if (!diff[PERIOD_W]) begin
          rem <= diff[PERIOD_W-1:0];
          quo <= {quo[PERIOD_W-2:0], 1'b1};
        end else begin
          rem <= trial[PERIOD_W-1:0];
          quo <= {quo[PERIOD_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      ST_SCALE: begin
        speed <= (scaled > SCALED_W'(SPEED_MAX)) ? SPEED_MAX : scaled[SPEED_W-1:0];
      end
      ST_OUT: begin
        if (load_out) begin
          m_tdata <= {{(M_TDATA_W - OUT_BITS){1'b0}}, (median != '0), speed, median, acc};
        end
      end
      default: ;
    endcase
  end

endmodule
